[design/md2_pkg.sv]
// MD2 digest block: shared constants, command type and the pi substitution table.
// No dependencies; imported by md2_front, md2_back and md2_message_digest_core.
package md2_pkg;

  localparam int unsigned BlkBytes  = 16;
  localparam int unsigned WorkBytes = 48;
  localparam int unsigned Rounds    = 18;
  localparam int unsigned QDepth    = 2;

  // One classified input item as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eom;
  } md2_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

[design/md2_message_digest_core.sv]
// MD2 message digest core: top level joining the input front end and the digest back end.
// Depends on md2_pkg, md2_front and md2_back.
//
// Usage:
//   Input queue: drive data_byte_i, byte_valid_i, end_of_message_i and raise push;
//   the item is taken on a clock edge with push high and full low. An item with
//   byte_valid_i low and end_of_message_i low is taken and dropped.
//   Output queue: while empty is low, digest_byte_o, digest_index_o and
//   digest_last_o show the oldest digest byte; it is taken on an edge with pop high.
//   A finalizing item yields 16 digest bytes, index 0 first, digest_last_o on the last.
//   Processing: a byte that does not complete a block is stored by the back end.
//   A completed block gets a checksum pass over its 16 bytes, a setup step and a
//   compression of 18 rounds of 48 bytes through one substitution lookup per cycle.
//   Finalizing adds up to 16 pad bytes, one block compression, a checksum load step
//   and a second compression.
//   A two-entry queue between front and back keeps taking items while the back end
//   works or while the digest waits. If the receiver stalls, the back end holds the
//   digest and takes no further command until all 16 bytes are popped, then returns
//   to the reset state. Reset clears the queue, chain state, checksum and fill count.
module md2_message_digest_core
  import md2_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       byte_valid_i,
  input  logic       end_of_message_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] digest_byte_o,
  output logic [3:0] digest_index_o,
  output logic       digest_last_o
);

  logic     cmd_valid, cmd_pop;
  md2_cmd_t cmd;

  md2_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  md2_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .digest_byte_o  (digest_byte_o),
    .digest_index_o (digest_index_o),
    .digest_last_o  (digest_last_o)
  );

endmodule

[design/md2_front.sv]
// MD2 front end: accepts input items, drops empty ones, queues commands for the back end.
// Depends on md2_pkg.
module md2_front
  import md2_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  logic [7:0] data_byte_i,
  input  logic     byte_valid_i,
  input  logic     end_of_message_i,
  output logic     cmd_valid_o,
  output md2_cmd_t cmd_o,
  input  logic     cmd_pop_i
);

  md2_cmd_t   q_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       accept, keep, deq;

  assign full        = (count_q == 2'(QDepth));
  assign accept      = push && !full;
  // drop items that carry neither a byte nor an end of message
  assign keep        = accept && (byte_valid_i || end_of_message_i);
  assign cmd_valid_o = (count_q != 2'd0);
  assign deq         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (keep) wr_ptr_q <= ~wr_ptr_q;
      if (deq) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(keep) - 2'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      q_q[wr_ptr_q] <= '{data: data_byte_i, valid: byte_valid_i, eom: end_of_message_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'(QDepth))
    else $error("md2_front: queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("md2_front: pointers disagree on empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !byte_valid_i && !end_of_message_i && !deq) |=> $stable(count_q))
    else $error("md2_front: empty item entered the queue");

endmodule

[design/md2_back.sv]
// MD2 back end: block buffer, checksum, 48-byte rotating work line and digest readout.
// Depends on md2_pkg.
module md2_back
  import md2_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  md2_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     empty,
  input  logic     pop,
  output logic [7:0] digest_byte_o,
  output logic [3:0] digest_index_o,
  output logic     digest_last_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_CKSUM  = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_ROUND  = 3'd4;
  localparam logic [2:0] ST_LOADCK = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  // w[0..15] chain state, w[16..31] block buffer, w[32..47] chain ^ block
  logic [7:0] w_q [WorkBytes];
  logic [7:0] w_d [WorkBytes];
  logic [7:0] c_q [BlkBytes];
  logic [7:0] c_d [BlkBytes];
  logic [2:0] state_q, state_d;
  logic [3:0] fill_q, fill_d;
  logic [5:0] step_q, step_d;
  logic [4:0] round_q, round_d;
  logic [7:0] tv_q, tv_d;
  logic [7:0] last_q, last_d;
  logic [4:0] pad_q, pad_d;
  logic       fin_q, fin_d, padded_q, padded_d, final_q, final_d;
  logic [7:0] sbox_idx, sbox_out, new_b;

  // one substitution lookup shared by checksum and compression
  assign sbox_idx = (state_q == ST_CKSUM) ? (w_q[{2'b01, step_q[3:0]}] ^ last_q) : tv_q;
  assign sbox_out = SBOX[sbox_idx];
  assign new_b    = ((state_q == ST_CKSUM) ? c_q[0] : w_q[0]) ^ sbox_out;

  assign empty          = (state_q != ST_EMIT);
  assign digest_byte_o  = w_q[{2'b00, step_q[3:0]}];
  assign digest_index_o = step_q[3:0];
  assign digest_last_o  = (step_q[3:0] == 4'(BlkBytes - 1));

  always_comb begin
    w_d       = w_q;
    c_d       = c_q;
    state_d   = state_q;
    fill_d    = fill_q;
    step_d    = step_q;
    round_d   = round_q;
    tv_d      = tv_q;
    last_d    = last_q;
    pad_d     = pad_q;
    fin_d     = fin_q;
    padded_d  = padded_q;
    final_d   = final_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          if (cmd_i.valid) begin
            w_d[{2'b01, fill_q}] = cmd_i.data;
            fill_d = fill_q + 4'd1;
          end
          if (cmd_i.eom) fin_d = 1'b1;
          if (cmd_i.valid && fill_q == 4'(BlkBytes - 1)) begin
            state_d = ST_CKSUM;
            step_d  = '0;
            last_d  = c_q[BlkBytes-1];
          end else if (cmd_i.eom) begin
            state_d  = ST_PAD;
            pad_d    = 5'(BlkBytes) - {1'b0, fill_d};
            padded_d = 1'b1;
          end
        end
      end
      ST_PAD: begin
        w_d[{2'b01, fill_q}] = {3'b000, pad_q};
        fill_d = fill_q + 4'd1;
        if (fill_q == 4'(BlkBytes - 1)) begin
          state_d = ST_CKSUM;
          step_d  = '0;
          last_d  = c_q[BlkBytes-1];
        end
      end
      ST_CKSUM: begin
        // rotate the checksum through its update point
        for (int k = 0; k < BlkBytes - 1; k++) c_d[k] = c_q[k+1];
        c_d[BlkBytes-1] = new_b;
        last_d = new_b;
        step_d = step_q + 6'd1;
        if (step_q[3:0] == 4'(BlkBytes - 1)) state_d = ST_PREP;
      end
      ST_PREP: begin
        for (int k = 0; k < BlkBytes; k++) w_d[2*BlkBytes+k] = w_q[k] ^ w_q[BlkBytes+k];
        tv_d    = '0;
        round_d = '0;
        step_d  = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        // one byte per cycle; a full round of shifts over the 48-byte line brings it back in place
        for (int k = 0; k < WorkBytes - 1; k++) w_d[k] = w_q[k+1];
        w_d[WorkBytes-1] = new_b;
        if (step_q == 6'(WorkBytes - 1)) begin
          tv_d    = new_b + {3'b000, round_q};
          step_d  = '0;
          round_d = round_q + 5'd1;
          if (round_q == 5'(Rounds - 1)) begin
            if (final_q) begin
              state_d = ST_EMIT;
            end else if (fin_q && padded_q) begin
              state_d = ST_LOADCK;
            end else if (fin_q) begin
              state_d  = ST_PAD;
              pad_d    = 5'(BlkBytes);
              padded_d = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          tv_d   = new_b;
          step_d = step_q + 6'd1;
        end
      end
      ST_LOADCK: begin
        for (int k = 0; k < BlkBytes; k++) w_d[BlkBytes+k] = c_q[k];
        final_d = 1'b1;
        state_d = ST_PREP;
      end
      ST_EMIT: begin
        if (pop) begin
          step_d = step_q + 6'd1;
          if (step_q[3:0] == 4'(BlkBytes - 1)) begin
            // digest delivered: return to the reset state
            for (int k = 0; k < BlkBytes; k++) begin
              w_d[k] = '0;
              c_d[k] = '0;
            end
            fill_d   = '0;
            fin_d    = 1'b0;
            padded_d = 1'b0;
            final_d  = 1'b0;
            step_d   = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WorkBytes; k++) w_q[k] <= '0;
      for (int k = 0; k < BlkBytes; k++) c_q[k] <= '0;
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      step_q   <= '0;
      round_q  <= '0;
      tv_q     <= '0;
      last_q   <= '0;
      pad_q    <= '0;
      fin_q    <= 1'b0;
      padded_q <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      w_q      <= w_d;
      c_q      <= c_d;
      state_q  <= state_d;
      fill_q   <= fill_d;
      step_q   <= step_d;
      round_q  <= round_d;
      tv_q     <= tv_d;
      last_q   <= last_d;
      pad_q    <= pad_d;
      fin_q    <= fin_d;
      padded_q <= padded_d;
      final_q  <= final_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND || state_q == ST_CKSUM) |-> (fill_q == 4'd0))
    else $error("md2_back: compression over a partial block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (round_q < 5'(Rounds) && step_q < 6'(WorkBytes)))
    else $error("md2_back: round counters out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (fin_q && padded_q && final_q))
    else $error("md2_back: digest shown before finalization");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && pop && digest_last_o) |=> (state_q == ST_IDLE && fill_q == 4'd0))
    else $error("md2_back: no return to reset state after digest");

endmodule

[verif/md2_message_digest_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for md2_message_digest_core: byte messages in, MD2 digests out.
// Depends on md2_pkg (command type, substitution table) and the core's RTL.
module md2_message_digest_core_tb
  import md2_pkg::*;
();

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned RstCycles  = 11;
  localparam int unsigned MaxCycles  = 1_000_000;
  localparam int unsigned DrainWait  = 2000;
  localparam int unsigned LongHold   = 3000;
  localparam int unsigned HoldAtPop  = 37;
  localparam int unsigned RandItems  = 170;

  typedef struct packed {
    logic [7:0] dbyte;
    logic [3:0] idx;
    logic       last;
  } digest_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte_i = 8'h00;
  logic       byte_valid_i = 1'b0;
  logic       end_of_message_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] digest_byte_o;
  logic [3:0] digest_index_o;
  logic       digest_last_o;

  md2_cmd_t     msg_items [$];
  digest_beat_t digest_fifo [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;

  // Predictor state
  logic [7:0]  chain_st [BlkBytes];
  logic [7:0]  cksum_st [BlkBytes];
  logic [7:0]  blk_buf [BlkBytes];
  int unsigned fill_cnt;

  md2_message_digest_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte_i),
    .byte_valid_i    (byte_valid_i),
    .end_of_message_i(end_of_message_i),
    .empty           (empty),
    .pop             (pop),
    .digest_byte_o   (digest_byte_o),
    .digest_index_o  (digest_index_o),
    .digest_last_o   (digest_last_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  function automatic void clear_hash_state();
    for (int k = 0; k < BlkBytes; k++) begin
      chain_st[k] = 8'h00;
      cksum_st[k] = 8'h00;
      blk_buf[k]  = 8'h00;
    end
    fill_cnt = 0;
  endfunction

  function automatic void md2_compress_block(input logic [7:0] m [BlkBytes]);
    logic [7:0] w [WorkBytes];
    logic [7:0] t;
    logic [7:0] carry;
    t = 8'h00;
    for (int k = 0; k < BlkBytes; k++) begin
      w[k]      = chain_st[k];
      w[k + 16] = m[k];
      w[k + 32] = chain_st[k] ^ m[k];
    end
    for (int r = 0; r < Rounds; r++) begin
      for (int k = 0; k < WorkBytes; k++) begin
        w[k] = w[k] ^ SBOX[t];
        t    = w[k];
      end
      t = t + 8'(r);
    end
    for (int k = 0; k < BlkBytes; k++) chain_st[k] = w[k];
    carry = cksum_st[BlkBytes - 1];
    for (int k = 0; k < BlkBytes; k++) begin
      cksum_st[k] = cksum_st[k] ^ SBOX[m[k] ^ carry];
      carry       = cksum_st[k];
    end
  endfunction

  function automatic void md2_absorb_byte(input logic [7:0] b);
    blk_buf[fill_cnt] = b;
    fill_cnt++;
    if (fill_cnt == BlkBytes) begin
      md2_compress_block(blk_buf);
      fill_cnt = 0;
    end
  endfunction

  // Absorb one accepted item; on end of message pad, fold in the checksum and
  // queue the 16 digest bytes.
  function automatic void md2_absorb_item(input md2_cmd_t c);
    logic [7:0] padv;
    logic [7:0] ck [BlkBytes];
    if (c.valid) md2_absorb_byte(c.data);
    if (c.eom) begin
      padv = 8'(BlkBytes - fill_cnt);
      for (int k = 0; k < padv; k++) md2_absorb_byte(padv);
      ck = cksum_st;
      md2_compress_block(ck);
      for (int k = 0; k < BlkBytes; k++)
        digest_fifo.push_back('{dbyte: chain_st[k], idx: 4'(k), last: (k == BlkBytes - 1)});
      clear_hash_state();
    end
  endfunction

  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic void add_item(input logic [7:0] d, input logic v, input logic e);
    msg_items.push_back('{data: d, valid: v, eom: e});
  endfunction

  // Sender: hold the item until accepted, then idle for a drawn number of cycles.
  int unsigned tx_wait;
  always @(posedge clk_i or negedge rst_ni) begin : sender
    md2_cmd_t    nxt;
    int unsigned gap;
    if (!rst_ni) begin
      push             <= 1'b0;
      data_byte_i      <= 8'h00;
      byte_valid_i     <= 1'b0;
      end_of_message_i <= 1'b0;
      tx_wait          <= 0;
    end else if (push && !full) begin
      md2_absorb_item('{data: data_byte_i, valid: byte_valid_i, eom: end_of_message_i});
      gap = draw_wait();
      if (gap == 0 && msg_items.size() != 0) begin
        nxt = msg_items.pop_front();
        {data_byte_i, byte_valid_i, end_of_message_i} <= nxt;
      end else begin
        push    <= 1'b0;
        tx_wait <= gap;
      end
    end else if (!push) begin
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
      end else if (msg_items.size() != 0) begin
        nxt = msg_items.pop_front();
        {data_byte_i, byte_valid_i, end_of_message_i} <= nxt;
        push <= 1'b1;
      end
    end
  end

  // Receiver: check each popped digest byte, stall at random, and once hold
  // off long enough for the input side to back up.
  int unsigned rx_wait;
  int unsigned pop_cnt;
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    digest_beat_t want;
    int unsigned  gap;
    if (!rst_ni) begin
      pop     <= 1'b0;
      rx_wait <= 0;
      pop_cnt <= 0;
    end else if (pop && !empty) begin
      if (digest_fifo.size() == 0) begin
        $display("%0t: unexpected digest byte expected none actual byte=%02h idx=%0d last=%0b",
                 $time, digest_byte_o, digest_index_o, digest_last_o);
        mismatch_cnt++;
      end else begin
        want = digest_fifo.pop_front();
        if (digest_byte_o !== want.dbyte) begin
          $display("%0t: digest_byte expected %02h actual %02h",
                   $time, want.dbyte, digest_byte_o);
          mismatch_cnt++;
        end
        if (digest_index_o !== want.idx) begin
          $display("%0t: digest_index expected %0d actual %0d",
                   $time, want.idx, digest_index_o);
          mismatch_cnt++;
        end
        if (digest_last_o !== want.last) begin
          $display("%0t: digest_last expected %0b actual %0b",
                   $time, want.last, digest_last_o);
          mismatch_cnt++;
        end
      end
      pop_cnt <= pop_cnt + 1;
      gap = (pop_cnt + 1 == HoldAtPop) ? LongHold : draw_wait();
      if (gap != 0) begin
        pop     <= 1'b0;
        rx_wait <= gap;
      end
    end else if (!pop) begin
      if (rx_wait != 0) rx_wait <= rx_wait - 1;
      else pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned len;
    logic        eom_on_byte;
    clear_hash_state();

    // Empty message, single bytes at both extremes, an ignored item, end
    // without a byte, and a block completed by the ending byte.
    add_item(8'($urandom), 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'($urandom), 1'b0, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'($urandom), 1'b0, 1'b1);
    for (int k = 0; k < BlkBytes; k++)
      add_item(8'(k * 17), 1'b1, (k == BlkBytes - 1));

    counted = 0;
    while (counted < RandItems) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 50) : $urandom_range(0, 20);
      eom_on_byte = (len != 0) && $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        // drop in an ignored item now and then
        if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
        add_item(8'($urandom), 1'b1, eom_on_byte && (k == len - 1));
        counted++;
      end
      if (!eom_on_byte) begin
        add_item(8'($urandom), 1'b0, 1'b1);
        counted++;
      end
    end

    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (msg_items.size() != 0 || push || digest_fifo.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_cnt == 0 && digest_fifo.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
